// File: rtl/ring_track_histogram_filter_top_assert.svh
// Assertion macros used by the checker of the ring track filter.
`ifndef RING_TRACK_HISTOGRAM_FILTER_TOP_ASSERT_SVH
`define RING_TRACK_HISTOGRAM_FILTER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define RTHF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define RTHF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rthf_pkg.sv
// Types, constants and helpers of the ring track histogram filter.
`default_nettype none
package rthf_pkg;

  localparam int unsigned PROB_W  = 25;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned HIT_W   = 8;
  localparam int unsigned QPOS_W  = 6;
  localparam int unsigned SUM_W   = 29;
  localparam int unsigned DEN_W   = 29;
  localparam int unsigned PROD_W  = 50;
  localparam int unsigned REM_W   = 30;
  localparam int unsigned CNT_W   = 5;

  localparam logic [PROB_W-1:0] ONE_Q24 = 25'h1000000;
  localparam logic [PROB_W-1:0] HALF_LSB = 25'h0800000;
  localparam logic [CNT_W-1:0]  DIV_STEPS_M1 = 5'd24;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_PROB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_REL  = 2'd1;

  typedef struct packed {
    logic              start;
    logic              div;
    logic [PROB_W-1:0] a;
    logic [PROB_W-1:0] m;
    logic [DEN_W-1:0]  d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] res;
  } md_rsp_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_CHK,
    MD_DIV
  } md_state_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_QMOD,
    S_SNEXT,
    S_WS_RD,
    S_WS_ACC,
    S_SE_RD,
    S_SE_GO,
    S_SE_WAIT,
    S_MV_RD,
    S_MV_GO,
    S_MV_WAIT,
    S_MV_WR,
    S_OUT_RD,
    S_OUT_ACC,
    S_DONE
  } seq_state_t;

  function automatic logic [PROB_W-1:0] sat_one(input logic [SUM_W-1:0] v);
    sat_one = (v > SUM_W'(ONE_Q24)) ? ONE_Q24 : v[PROB_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/rthf_if.sv
// Channel interfaces of the ring track filter: input, result and configuration.
`default_nettype none
interface rthf_in_if import rthf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HIT_W-1:0]  sensor_hits;
  logic [QPOS_W-1:0] query_position;
  modport source (output valid, sensor_hits, query_position, input ready);
  modport sink (input valid, sensor_hits, query_position, output ready);
endinterface

interface rthf_out_if import rthf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] position_prob;
  modport source (output valid, position_prob, input ready);
  modport sink (input valid, position_prob, output ready);
endinterface

interface rthf_cfg_if import rthf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/ring_track_histogram_filter_top.sv
// Top level of the ring track histogram filter: sequencer, belief memory, config.
`default_nettype none
// Grid Bayes filter over NUM_POSITIONS ring positions times (2*MAX_SPEED+1) speeds,
// Q1.24 probabilities held in one single-port-write memory of two banks. After
// reset a clearing pass writes the uniform belief into all NUM_STATES states (448 by
// default), one state per cycle, with the input held off. Each input transaction
// is worked one at a time: for every fired sensor the block reads the seven watched
// states and then rescales every state through the shared multiply/divide unit and
// its 25-step restoring divide. The motion update gathers three rounded products
// per state into the other bank (two at the edge speeds, where one term is
// skipped), then swaps banks and sums the queried position over all speeds. A
// finished result waits in the output register while the next transaction is taken.
module ring_track_histogram_filter_top import rthf_pkg::*; #(
  parameter int NUM_POSITIONS = 64,
  parameter int MAX_SPEED     = 3,
  parameter int NUM_SENSORS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rthf_in_if.sink    in_ch,
  rthf_out_if.source out_ch,
  rthf_cfg_if.sink   cfg_ch
);

  localparam int NUM_SPEEDS = 2 * MAX_SPEED + 1;
  localparam int NUM_STATES = NUM_POSITIONS * NUM_SPEEDS;
  localparam int PW  = $clog2(NUM_POSITIONS);
  localparam int SPW = $clog2(NUM_SPEEDS);
  localparam int SW  = $clog2(NUM_STATES);
  localparam int AW  = $clog2(2 * NUM_STATES);
  localparam int KMAX = (NUM_SENSORS < HIT_W) ? NUM_SENSORS : HIT_W;
  localparam int STEP5 = 5 % NUM_POSITIONS;
  localparam int M0 = MAX_SPEED % NUM_POSITIONS;
  localparam logic [PROB_W-1:0] INIT_VAL =
    PROB_W'((2**24 + NUM_STATES / 2) / NUM_STATES);
  localparam logic [SW-1:0]  S_SW    = SW'(NUM_SPEEDS);
  localparam logic [SW-1:0]  LAST_I  = SW'(NUM_STATES - 1);
  localparam logic [SPW-1:0] LAST_SP = SPW'(NUM_SPEEDS - 1);
  localparam logic [SPW-1:0] PRE_SP  = SPW'(NUM_SPEEDS - 2);
  localparam logic [PW-1:0]  LAST_P  = PW'(NUM_POSITIONS - 1);
  localparam logic [DEN_W-1:0] D_SPEEDS = DEN_W'(NUM_SPEEDS);
  localparam logic [DEN_W-1:0] D_OTHERS = DEN_W'(NUM_STATES - NUM_SPEEDS);

  seq_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  chg_r;
  logic [CFG_W-1:0]  rel_r;
  logic              bank_r, bank_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [SPW-1:0]    spd_r, spd_nxt;
  logic [1:0]        term_r, term_nxt;
  logic [PW-1:0]     srcbase_r, srcbase_nxt;
  logic [PW-1:0]     srcpos_r, srcpos_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [PW-1:0]     wpos_r, wpos_nxt;
  logic [HIT_W-1:0]  hits_r, hits_nxt;
  logic [QPOS_W-1:0] q_r, q_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0] out_prob_r, out_prob_nxt;

  logic [PROB_W-1:0] mem [2*NUM_STATES];
  logic [PROB_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [PROB_W-1:0] wr_data;
  logic [SW-1:0]     rd_idx, wr_idx;
  logic              rd_bank, wr_bank;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic              in_acc, out_acc;
  logic [SW-1:0]     wbase;
  logic              watched;
  logic [PROB_W-1:0] rel25, rest25, chg25, stay25;
  logic              term_ok;
  logic [SPW-1:0]    src_spd;
  logic              out_free;
  logic [PW:0]       wpos_sum, sb_sum;
  logic [PW-1:0]     wpos_adv, sb_adv, sp_dec;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign rel25  = {1'b0, rel_r, 8'b0};
  assign rest25 = ONE_Q24 - rel25;
  assign chg25  = {1'b0, chg_r, 8'b0};
  assign stay25 = ONE_Q24 - chg25;

  assign wbase   = SW'(wpos_r) * S_SW;
  assign watched = (idx_r >= wbase) && (idx_r < wbase + S_SW);

  // skip gather terms that fall off the speed range
  assign term_ok = !((term_r == 2'd1 && spd_r == '0) || (term_r == 2'd2 && spd_r == LAST_SP));
  assign src_spd = (term_r == 2'd1) ? spd_r - 1'b1 :
                   (term_r == 2'd2) ? spd_r + 1'b1 : spd_r;

  // ring steps with one wrap
  assign wpos_sum = {1'b0, wpos_r} + (PW+1)'(STEP5);
  assign wpos_adv = (wpos_sum >= (PW+1)'(NUM_POSITIONS)) ?
                    PW'(wpos_sum - (PW+1)'(NUM_POSITIONS)) : wpos_sum[PW-1:0];
  assign sb_sum   = {1'b0, srcbase_r} + (PW+1)'(1);
  assign sb_adv   = (sb_sum >= (PW+1)'(NUM_POSITIONS)) ? '0 : sb_sum[PW-1:0];
  assign sp_dec   = (srcpos_r == '0) ? LAST_P : srcpos_r - 1'b1;

  rthf_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (idx_r == LAST_I) state_nxt = S_IDLE;
      S_IDLE:    if (in_acc) state_nxt = S_QMOD;
      S_QMOD:    if (!(32'(q_r) >= 32'(NUM_POSITIONS))) state_nxt = S_SNEXT;
      S_SNEXT: begin
        if (k_r == 4'(KMAX)) state_nxt = S_MV_RD;
        else if (hits_r[k_r[2:0]]) state_nxt = S_WS_RD;
      end
      S_WS_RD:   state_nxt = S_WS_ACC;
      S_WS_ACC:  state_nxt = (spd_r == LAST_SP) ? S_SE_RD : S_WS_RD;
      S_SE_RD:   state_nxt = S_SE_GO;
      S_SE_GO:   state_nxt = S_SE_WAIT;
      S_SE_WAIT: begin
        if (md_rsp.done) state_nxt = (idx_r == LAST_I) ? S_SNEXT : S_SE_RD;
      end
      S_MV_RD: begin
        if (term_ok) state_nxt = S_MV_GO;
        else if (term_r == 2'd2) state_nxt = S_MV_WR;
      end
      S_MV_GO:   state_nxt = S_MV_WAIT;
      S_MV_WAIT: begin
        if (md_rsp.done) state_nxt = (term_r == 2'd2) ? S_MV_WR : S_MV_RD;
      end
      S_MV_WR: begin
        if (spd_r == LAST_SP && pos_r == LAST_P) state_nxt = S_OUT_RD;
        else state_nxt = S_MV_RD;
      end
      S_OUT_RD:  state_nxt = S_OUT_ACC;
      S_OUT_ACC: state_nxt = (spd_r == LAST_SP) ? S_DONE : S_OUT_RD;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    bank_nxt      = bank_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    spd_nxt       = spd_r;
    term_nxt      = term_r;
    srcbase_nxt   = srcbase_r;
    srcpos_nxt    = srcpos_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    wpos_nxt      = wpos_r;
    hits_nxt      = hits_r;
    q_nxt         = q_r;
    out_prob_nxt  = out_prob_r;
    out_valid_nxt = out_valid_r && !out_acc;
    rd_idx        = idx_r;
    rd_bank       = bank_r;
    wr_en         = 1'b0;
    wr_idx        = idx_r;
    wr_bank       = bank_r;
    wr_data       = rd_data_r;
    md_req        = '0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = INIT_VAL;
        idx_nxt = idx_r + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          hits_nxt = in_ch.sensor_hits;
          q_nxt    = in_ch.query_position;
          k_nxt    = '0;
          wpos_nxt = '0;
        end
      end
      S_QMOD: begin
        if (32'(q_r) >= 32'(NUM_POSITIONS)) q_nxt = q_r - QPOS_W'(NUM_POSITIONS);
      end
      S_SNEXT: begin
        spd_nxt = '0;
        acc_nxt = '0;
        if (k_r == 4'(KMAX)) begin
          // start the motion gather at position 0, speed index 0
          pos_nxt     = '0;
          term_nxt    = '0;
          srcbase_nxt = PW'(M0);
          srcpos_nxt  = PW'(M0);
        end else if (!hits_r[k_r[2:0]]) begin
          k_nxt    = k_r + 4'd1;
          wpos_nxt = wpos_adv;
        end
      end
      S_WS_RD: begin
        rd_idx = wbase + SW'(spd_r);
      end
      S_WS_ACC: begin
        acc_nxt = acc_r + SUM_W'(rd_data_r);
        if (spd_r == LAST_SP) idx_nxt = '0;
        else spd_nxt = spd_r + 1'b1;
      end
      S_SE_GO: begin
        md_req.start = 1'b1;
        md_req.div   = 1'b1;
        if (watched) begin
          if (acc_r == '0) begin
            md_req.a = rel25;
            md_req.m = PROB_W'(1);
            md_req.d = D_SPEEDS;
          end else begin
            md_req.a = rd_data_r;
            md_req.m = rel25;
            md_req.d = acc_r;
          end
        end else begin
          if (acc_r >= SUM_W'(ONE_Q24)) begin
            md_req.a = rest25;
            md_req.m = PROB_W'(1);
            md_req.d = D_OTHERS;
          end else begin
            md_req.a = rd_data_r;
            md_req.m = rest25;
            md_req.d = SUM_W'(ONE_Q24) - acc_r;
          end
        end
      end
      S_SE_WAIT: begin
        if (md_rsp.done) begin
          wr_en   = 1'b1;
          wr_data = md_rsp.res;
          if (idx_r == LAST_I) begin
            k_nxt    = k_r + 4'd1;
            wpos_nxt = wpos_adv;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_MV_RD: begin
        rd_idx = SW'(srcpos_r) * S_SW + SW'(src_spd);
        if (!term_ok && term_r != 2'd2) term_nxt = term_r + 2'd1;
      end
      S_MV_GO: begin
        md_req.start = 1'b1;
        md_req.a     = rd_data_r;
        if (term_r == 2'd0) md_req.m = stay25;
        else if (term_r == 2'd1) md_req.m = (spd_r == SPW'(1)) ? chg25 : chg25 >> 1;
        else md_req.m = (spd_r == PRE_SP) ? chg25 : chg25 >> 1;
      end
      S_MV_WAIT: begin
        if (md_rsp.done) begin
          acc_nxt = acc_r + SUM_W'(md_rsp.res);
          if (term_r != 2'd2) term_nxt = term_r + 2'd1;
        end
      end
      S_MV_WR: begin
        wr_en    = 1'b1;
        wr_bank  = !bank_r;
        wr_idx   = SW'(pos_r) * S_SW + SW'(spd_r);
        wr_data  = sat_one(acc_r);
        acc_nxt  = '0;
        term_nxt = '0;
        if (spd_r == LAST_SP) begin
          spd_nxt = '0;
          if (pos_r == LAST_P) begin
            bank_nxt = !bank_r;
          end else begin
            pos_nxt     = pos_r + 1'b1;
            srcbase_nxt = sb_adv;
            srcpos_nxt  = sb_adv;
          end
        end else begin
          spd_nxt    = spd_r + 1'b1;
          srcpos_nxt = sp_dec;
        end
      end
      S_OUT_RD: begin
        rd_idx = SW'(q_r) * S_SW + SW'(spd_r);
      end
      S_OUT_ACC: begin
        acc_nxt = acc_r + SUM_W'(rd_data_r);
        if (spd_r != LAST_SP) spd_nxt = spd_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_prob_nxt  = sat_one(acc_r);
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = rd_bank ? AW'(rd_idx) + AW'(NUM_STATES) : AW'(rd_idx);
  assign wr_addr = wr_bank ? AW'(wr_idx) + AW'(NUM_STATES) : AW'(wr_idx);

  // Belief memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bank_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      chg_r       <= 16'd13107;
      rel_r       <= 16'd32768;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      // hold config unless a write transaction lands
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_CHANGE_PROB: chg_r <= cfg_ch.data;
          CFG_SENSOR_REL:  rel_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
    pos_r      <= pos_nxt;
    spd_r      <= spd_nxt;
    term_r     <= term_nxt;
    srcbase_r  <= srcbase_nxt;
    srcpos_r   <= srcpos_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    wpos_r     <= wpos_nxt;
    hits_r     <= hits_nxt;
    q_r        <= q_nxt;
    out_prob_r <= out_prob_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.position_prob = out_prob_r;

endmodule
`default_nettype wire

// File: rtl/rthf_muldiv.sv
// Shared multiply unit with rounding shift or rounding restoring divide.
`default_nettype none
module rthf_muldiv import rthf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_state_t         state_r, state_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [DEN_W-1:0]  d_r, d_nxt;
  logic              div_r, div_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [PROB_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROB_W-1:0] res_r, res_nxt;
  logic              done_r, done_nxt;

  logic [PROD_W-1:0] num;
  logic [PROD_W-1:0] rnd;
  logic [53:0]       lim;
  logic              sat;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign num   = prod_r + {{(PROD_W-DEN_W+1){1'b0}}, d_r[DEN_W-1:1]};
  assign rnd   = prod_r + {{(PROD_W-PROB_W){1'b0}}, HALF_LSB};
  assign lim   = {1'b0, d_r, 24'b0} + {25'b0, d_r};
  assign sat   = {4'b0, num} >= lim;
  assign trial = {rem_r[REM_W-2:0], quo_r[PROB_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_CHK;
      MD_CHK:  if (div_r && !sat) state_nxt = MD_DIV;
               else state_nxt = MD_IDLE;
      MD_DIV:  if (cnt_r == DIV_STEPS_M1) state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    prod_nxt = prod_r;
    d_nxt    = d_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          prod_nxt = req.a * req.m;
          d_nxt    = req.d;
          div_nxt  = req.div;
        end
      end
      MD_CHK: begin
        cnt_nxt = '0;
        if (!div_r) begin
          res_nxt  = rnd[48:24];
          done_nxt = 1'b1;
        end else if (sat) begin
          res_nxt  = ONE_Q24;
          done_nxt = 1'b1;
        end else begin
          // top part stays below the divisor since the quotient fits 25 bits
          rem_nxt = {{(REM_W-PROB_W){1'b0}}, num[PROD_W-1:PROB_W]};
          quo_nxt = num[PROB_W-1:0];
        end
      end
      MD_DIV: begin
        rem_nxt = ge ? (trial - {1'b0, d_r}) : trial;
        quo_nxt = {quo_r[PROB_W-2:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_STEPS_M1) begin
          res_nxt  = {quo_r[PROB_W-2:0], ge};
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    prod_r <= prod_nxt;
    d_r    <= d_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

// File: rtl/rthf_checker.sv
// Port-level checker of the ring track filter and its bind to the top level.
`default_nettype none
`include "ring_track_histogram_filter_top_assert.svh"
module rthf_checker import rthf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [PROB_W-1:0] out_prob
);

  `RTHF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `RTHF_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_prob), "stalled data moved")
  `RTHF_ASSERT_IMP(a_out_range, out_valid, out_prob <= ONE_Q24, "probability above one")
  `RTHF_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "took a second transaction")
  `RTHF_ASSERT_NXT(a_no_instant, in_valid && in_ready && !out_valid, !out_valid,
                   "result without work")

endmodule

bind ring_track_histogram_filter_top rthf_checker u_rthf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_prob  (out_ch.position_prob)
);
`default_nettype wire

// File: dv/ring_track_histogram_filter_top_test.sv
// Self-checking testbench of the ring track histogram filter: directed table plus random ticks.
`timescale 1ns / 1ps
module ring_track_histogram_filter_top_test;
  import rthf_pkg::*;

  localparam int NPOS    = 64;
  localparam int MSPD    = 3;
  localparam int NSPD    = 2 * MSPD + 1;
  localparam int NSTATE  = NPOS * NSPD;
  localparam longint unsigned ONE = 64'd16777216;
  localparam longint CYCLE_LIMIT = 80_000_000;
  localparam int LONG_HOLD = 30000;
  localparam int SETTLE = 100;

  typedef enum logic [1:0] { ROW_ITEM, ROW_CP, ROW_REL } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [HIT_W-1:0]  hits;
    logic [QPOS_W-1:0] qpos;
    logic [CFG_W-1:0]  value;
    logic              typed;
    logic [PROB_W-1:0] prob;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  rthf_in_if  in_ch ();
  rthf_out_if out_ch ();
  rthf_cfg_if cfg_ch ();

  ring_track_histogram_filter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // Own copy of the filter: belief grid and both registers.
  longint unsigned belief_q[NSTATE];
  longint unsigned change_q16;
  longint unsigned rel_q16;

  logic [PROB_W-1:0] prob_expected[$];
  int  fails;
  int  items_sent;
  int  results_seen;
  int  hit_ticks;
  longint cycles;
  bit  quiet;
  bit  long_hold_req;

  function automatic longint unsigned round_scale(longint unsigned a, longint unsigned m,
                                                  longint unsigned d);
    return (a * m + d / 2) / d;
  endfunction

  function automatic longint unsigned clip_one(longint unsigned v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic void reset_belief();
    change_q16 = 13107;
    rel_q16    = 32768;
    foreach (belief_q[i]) belief_q[i] = (ONE + NSTATE / 2) / NSTATE;
  endfunction

  // Rescale watched and unwatched mass after one sensor fires.
  function automatic void fire_sensor(int pos);
    longint unsigned rel, rest, wsum, v;
    int base;
    rel  = rel_q16 << 8;
    rest = ONE - rel;
    wsum = 0;
    base = pos * NSPD;
    for (int i = 0; i < NSPD; i++) wsum += belief_q[base + i];
    for (int i = 0; i < NSTATE; i++) begin
      if (i >= base && i < base + NSPD) begin
        if (wsum == 0) v = round_scale(rel, 1, NSPD);
        else v = round_scale(belief_q[i], rel, wsum);
      end else begin
        if (wsum >= ONE) v = round_scale(rest, 1, NSTATE - NSPD);
        else v = round_scale(belief_q[i], rest, ONE - wsum);
      end
      belief_q[i] = clip_one(v);
    end
  endfunction

  // Markov move: keep or nudge the speed, then advance the position with wrap.
  function automatic void move_belief();
    longint unsigned nxt[NSTATE];
    longint unsigned chg, stay, pr, up_w, dn_w;
    int p2;
    chg  = change_q16 << 8;
    stay = ONE - chg;
    foreach (nxt[i]) nxt[i] = 0;
    for (int p = 0; p < NPOS; p++) begin
      for (int j = -MSPD; j <= MSPD; j++) begin
        pr   = belief_q[p * NSPD + j + MSPD];
        up_w = (j == -MSPD) ? chg : chg / 2;
        dn_w = (j == MSPD) ? chg : chg / 2;
        p2 = (p + j + NPOS) % NPOS;
        nxt[p2 * NSPD + j + MSPD] += round_scale(pr, stay, ONE);
        if (j != MSPD) begin
          p2 = (p + j + 1 + NPOS) % NPOS;
          nxt[p2 * NSPD + j + 1 + MSPD] += round_scale(pr, up_w, ONE);
        end
        if (j != -MSPD) begin
          p2 = (p + j - 1 + NPOS) % NPOS;
          nxt[p2 * NSPD + j - 1 + MSPD] += round_scale(pr, dn_w, ONE);
        end
      end
    end
    foreach (belief_q[i]) belief_q[i] = clip_one(nxt[i]);
  endfunction

  function automatic logic [PROB_W-1:0] track_tick(logic [HIT_W-1:0] hits,
                                                   logic [QPOS_W-1:0] qpos);
    longint unsigned sum;
    int q;
    sum = 0;
    q = qpos % NPOS;
    for (int k = 0; k < HIT_W; k++) if (hits[k]) fire_sensor((k * 5) % NPOS);
    move_belief();
    for (int j = 0; j < NSPD; j++) sum += belief_q[q * NSPD + j];
    return PROB_W'(clip_one(sum));
  endfunction

  // Offer one tick; hold valid high until the transaction goes through.
  task automatic send_tick(logic [HIT_W-1:0] hits, logic [QPOS_W-1:0] qpos,
                           bit typed, logic [PROB_W-1:0] prob);
    logic [PROB_W-1:0] pred;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sensor_hits    <= hits;
    in_ch.query_position <= qpos;
    do @(posedge clk); while (!in_ch.ready);
    pred = track_tick(hits, qpos);
    prob_expected.insert(prob_expected.size(), typed ? prob : pred);
    items_sent++;
    if (hits != '0) hit_ticks++;
  endtask

  // Drain, let the block settle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (prob_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_CHANGE_PROB) change_q16 = value;
    else rel_q16 = value;
  endtask

  function automatic logic [HIT_W-1:0] pick_hits();
    int r;
    r = $urandom_range(0, 99);
    // Keep most ticks cheap: each fired sensor costs a full rescale pass.
    if (r < 55) return '0;
    if (r < 90) return HIT_W'(1) << $urandom_range(0, HIT_W - 1);
    return HIT_W'($urandom_range(0, 255));
  endfunction

  row_t dir_rows[] = '{
    '{ROW_CP,   8'h00, 6'd0,  16'd0,     1'b0, '0},
    // No motion change: the uniform grid just shifts, 7 * 37449 per position.
    '{ROW_ITEM, 8'h00, 6'd0,  16'd0,     1'b1, 25'd262143},
    '{ROW_ITEM, 8'h00, 6'd63, 16'd0,     1'b1, 25'd262143},
    '{ROW_CP,   8'h00, 6'd0,  16'hFFFF,  1'b0, '0},
    '{ROW_ITEM, 8'h01, 6'd0,  16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'h80, 6'd35, 16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'hFF, 6'd63, 16'd0,     1'b0, '0},
    // Zero reliability empties the watched states; fire again for the even share.
    '{ROW_REL,  8'h00, 6'd0,  16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'h01, 6'd0,  16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'h01, 6'd0,  16'd0,     1'b0, '0},
    '{ROW_REL,  8'h00, 6'd0,  16'hFFFF,  1'b0, '0},
    '{ROW_ITEM, 8'h02, 6'd5,  16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'h02, 6'd5,  16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'h55, 6'd20, 16'd0,     1'b0, '0},
    '{ROW_CP,   8'h00, 6'd0,  16'd13107, 1'b0, '0},
    '{ROW_REL,  8'h00, 6'd0,  16'd32768, 1'b0, '0},
    '{ROW_ITEM, 8'hAA, 6'd1,  16'd0,     1'b0, '0},
    '{ROW_ITEM, 8'h00, 6'd10, 16'd0,     1'b0, '0}
  };

  // Result side: random backpressure plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (prob_expected.size() == 0) begin
        $error("position_prob: unexpected result, actual %0d", out_ch.position_prob);
        fails++;
      end else begin
        logic [PROB_W-1:0] exp_prob;
        exp_prob = prob_expected.pop_front();
        if (out_ch.position_prob !== exp_prob) begin
          $error("position_prob: expected %0d, actual %0d", exp_prob, out_ch.position_prob);
          fails++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] cp_set[4];
    logic [CFG_W-1:0] rel_set[4];
    fails = 0;
    items_sent = 0;
    results_seen = 0;
    hit_ticks = 0;
    cycles = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    reset_belief();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sensor_hits <= '0;
    in_ch.query_position <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_CHANGE_PROB;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; config rows wait for the block to go idle.
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_CP: write_reg(CFG_CHANGE_PROB, dir_rows[r].value);
        ROW_REL: write_reg(CFG_SENSOR_REL, dir_rows[r].value);
        default: send_tick(dir_rows[r].hits, dir_rows[r].qpos,
                           dir_rows[r].typed, dir_rows[r].prob);
      endcase
    end

    // Random phases, each under its own register setting.
    cp_set  = '{CFG_W'($urandom), 16'd0,    CFG_W'($urandom), 16'hFFFF};
    rel_set = '{CFG_W'($urandom), 16'hFFFF, CFG_W'($urandom), CFG_W'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_CHANGE_PROB, cp_set[ph]);
      write_reg(CFG_SENSOR_REL, rel_set[ph]);
      if (ph == 1) long_hold_req = 1'b1;
      if (ph == 3) quiet = 1'b1;
      for (int n = 0; n < 31; n++) begin
        if (ph == 2 && n == 15) begin
          // Pause the sender until the pipeline has drained completely.
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (prob_expected.size() != 0) @(posedge clk);
        end
        send_tick(pick_hits(), QPOS_W'($urandom_range(0, 63)), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (prob_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d ticks (%0d with fired sensors), %0d results, in %0d cycles",
             items_sent, hit_ticks, results_seen, cycles);
    $display("register extremes and random settings, long output hold-off, drained pause");
    if (fails == 0 && prob_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
